[rtl/core/erfbr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Euler rate datapath.
// Fixed angle/rate formats, octant fold codes, series constants, output saturation.
// No dependencies.
package erfbr_pkg;

  // angle units: 1/128 degree
  localparam logic [15:0] FULL_TURN          = 16'd46080;
  localparam logic [15:0] HALF_TURN          = 16'd23040;
  localparam logic [15:0] QUARTER_TURN       = 16'd11520;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd34560;
  localparam logic [13:0] EIGHTH_TURN        = 14'd5760;
  localparam logic signed [15:0] PITCH_LIMIT = 16'sd11520;

  // Q30 constants
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30 = 30'h2000_0000;

  // angle to Q30 radians: pi_q30 / 23040 = 146408 + 19106 / 23040
  localparam logic [17:0] X_INT   = 18'd146408;
  localparam logic [14:0] X_FRAC  = 15'd19106;
  localparam logic [13:0] X_BIAS  = 14'd11520;
  // floor(n / 45) = (n * RCP45) >> 24 for n below 2^18
  localparam logic [18:0] RCP45   = 19'd372828;

  // horner steps, lane 0 is the sine series, lane 1 the cosine series
  // each step divides by d with round to nearest: (n + d/2) * ceil(2^s / d) >> s
  localparam logic [6:0] HORNER_HALF [2][6] = '{
    '{7'd55, 7'd36, 7'd21, 7'd10, 7'd3, 7'd0},
    '{7'd66, 7'd45, 7'd28, 7'd15, 7'd6, 7'd1}
  };
  localparam int unsigned HORNER_SHF [2][6] = '{
    '{38, 38, 37, 36, 34, 0},
    '{39, 38, 37, 36, 35, 32}
  };
  localparam logic [32:0] HORNER_MAG [2][6] = '{
    '{33'(((72'd1 << 38) + 72'd109) / 72'd110),
      33'(((72'd1 << 38) + 72'd71) / 72'd72),
      33'(((72'd1 << 37) + 72'd41) / 72'd42),
      33'(((72'd1 << 36) + 72'd19) / 72'd20),
      33'(((72'd1 << 34) + 72'd5) / 72'd6),
      33'd1},
    '{33'(((72'd1 << 39) + 72'd131) / 72'd132),
      33'(((72'd1 << 38) + 72'd89) / 72'd90),
      33'(((72'd1 << 37) + 72'd55) / 72'd56),
      33'(((72'd1 << 36) + 72'd29) / 72'd30),
      33'(((72'd1 << 35) + 72'd11) / 72'd12),
      33'(((72'd1 << 32) + 72'd1) / 72'd2)}
  };

  // output saturation
  localparam logic [23:0] RATE_MAX     = 24'h7F_FFFF;
  localparam logic [23:0] RATE_MIN     = 24'h80_0000;
  localparam logic [24:0] RATE_POS_MAG = 25'd8388607;
  localparam logic [24:0] RATE_NEG_MAG = 25'd8388608;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic  swp;
    quad_t quad;
  } octant_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
  } xpair_t;

  typedef struct packed {
    logic               guard;
    logic signed [15:0] p;
    logic signed [15:0] q;
    logic signed [15:0] r;
  } side_t;

  function automatic logic [23:0] sat_rate(input logic [24:0] mag, input logic ovf,
                                           input logic neg);
    logic [23:0] res;
    if (neg) begin
      if (ovf || mag >= RATE_NEG_MAG) res = RATE_MIN;
      else res = -mag[23:0];
    end else begin
      if (ovf || mag >= RATE_POS_MAG) res = RATE_MAX;
      else res = mag[23:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/euler_rates_from_body_rates.sv]
`timescale 1ns / 1ps
// Euler angle rates from roll/pitch attitude and body rates p, q, r.
// Fully pipelined: folded series sin/cos, products, two restoring dividers.
// Depends on erfbr_pkg.
//
// Usage:
//   Input channel (in_*): one attitude/body-rate sample per transfer.
//   Output channel (out_*): one result per input transfer, in order.
//   Both channels use valid/stall; a transfer happens when valid is high
//   and stall is low at a rising clock edge.
//   Depth: 56 register stages, and out_valid is the valid bit of the last one;
//   the depth is set by the 25 quotient bits of the roll and yaw dividers
//   (one bit per stage) after the sin/cos series and the product stages.
//   Throughput: one sample per cycle while the pipeline is not held (see Stall).
//   Stall: the whole pipeline holds while a result waits with out_stall
//   high; in_stall is high in exactly those cycles. Nothing is dropped
//   or repeated, and other cycles keep accepting even with a full pipe.
//   When |pitch| is 90 degrees or more, out_rates_valid is 0 and the
//   rates are 0. Rates saturate to 24 bits.
//   Reset (rst_n low, synchronous) empties the pipeline.
module euler_rates_from_body_rates
  import erfbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_body_roll_rate,
  input  logic signed [15:0] in_body_pitch_rate,
  input  logic signed [15:0] in_body_yaw_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_roll_angle_rate,
  output logic signed [23:0] out_pitch_angle_rate,
  output logic signed [23:0] out_heading_rate,
  output logic               out_rates_valid
);

  localparam int unsigned ST_OUT = 55;
  localparam int unsigned DIV_STEPS = 25;

  // pipeline control
  logic              pipe_adv;
  logic              vld_r [0:ST_OUT];
  side_t             side_r [0:ST_OUT-1];

  // angle reduction and series evaluation, per angle (0 roll, 1 pitch)
  logic signed [15:0] ang_r  [2];
  logic [12:0]        rf_r   [2];
  octant_t            oct_r  [2][1:19];
  logic [29:0]        xa2_r  [2];
  logic [26:0]        xm_r   [2];
  logic [36:0]        xq_r   [2];
  logic [29:0]        xa3_r  [2];
  logic [29:0]        x4_r   [2];
  logic [59:0]        xx_r   [2];
  logic [29:0]        x5_r   [2];
  xpair_t             xp_r   [2][6:16];
  logic [60:0]        prod_r [2][2][6];
  logic [63:0]        nm_r   [2][2][6];
  logic [30:0]        sf_r   [2];
  logic [30:0]        cf_r   [2];
  logic signed [31:0] sn_r   [2];
  logic signed [31:0] cs_r   [2];

  // rate products and rounding
  logic signed [47:0] qs_r, rc_r, qc_r, rs_r;
  logic signed [31:0] st_r [21:24];
  logic [30:0]        ct_r [21:ST_OUT-1];
  logic signed [48:0] a_r, pr_r;
  logic [47:0]        amag_r, prmag_r;
  logic               asgn_r, prsgn_r;
  logic signed [32:0] a16_r [24:26];
  logic signed [16:0] prate_r [24:ST_OUT-1];
  logic signed [47:0] pc_r;
  logic signed [64:0] as_r;
  logic signed [64:0] rnum_r;
  logic [63:0]        rmag_r;
  logic [61:0]        ymag_r;
  logic [1:0]         sgn_r [27:ST_OUT-1];

  // dividers, lane 0 roll rate, lane 1 yaw rate
  logic [71:0] nsum_r [2];
  logic [71:0] rem_r  [2][0:DIV_STEPS];
  logic        ov_r   [2][0:DIV_STEPS];
  logic [24:0] qb_r   [2][0:DIV_STEPS];

  // output register
  logic signed [23:0] out_roll_r, out_pitch_r, out_head_r;
  logic               out_rv_r;

  // the whole pipe moves unless a finished result is held
  assign pipe_adv  = !(vld_r[ST_OUT] && out_stall);
  assign in_stall  = !pipe_adv;
  assign out_valid = vld_r[ST_OUT];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ST_OUT; k++) vld_r[k] <= 1'b0;
    end else if (pipe_adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= ST_OUT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // input capture and side data carried to the end
  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      ang_r[0]       <= in_roll_angle;
      ang_r[1]       <= in_pitch_angle;
      side_r[0].guard <= (in_pitch_angle > -PITCH_LIMIT) && (in_pitch_angle < PITCH_LIMIT);
      side_r[0].p    <= in_body_roll_rate;
      side_r[0].q    <= in_body_pitch_rate;
      side_r[0].r    <= in_body_yaw_rate;
      for (int k = 1; k < ST_OUT; k++) side_r[k] <= side_r[k-1];
    end
  end

  for (genvar ag = 0; ag < 2; ag++) begin : g_ang
    logic [16:0] msum;
    logic [15:0] mm;
    logic [15:0] rq;
    quad_t       qd;
    logic        swp;
    logic [60:0] x2sum;
    logic [31:0] s1, c1, sneg, cneg;
    logic [63:0] csh;

    // reduce modulo a full turn, pick quadrant, fold to one octant
    assign msum = {ang_r[ag][15], ang_r[ag]} + (ang_r[ag][15] ? {1'b0, FULL_TURN} : 17'd0);
    assign mm   = msum[15:0];
    always_comb begin
      priority if (mm >= THREE_QUARTER_TURN) begin
        qd = QUAD_3;
        rq = mm - THREE_QUARTER_TURN;
      end else if (mm >= HALF_TURN) begin
        qd = QUAD_2;
        rq = mm - HALF_TURN;
      end else if (mm >= QUARTER_TURN) begin
        qd = QUAD_1;
        rq = mm - QUARTER_TURN;
      end else begin
        qd = QUAD_0;
        rq = mm;
      end
    end
    assign swp = rq > {2'b00, EIGHTH_TURN};

    assign x2sum = {1'b0, xx_r[ag]} + 61'(HALF_Q30);

    // final series values and quadrant signs
    assign csh  = nm_r[ag][1][5] >> HORNER_SHF[1][5];
    assign s1   = {1'b0, (oct_r[ag][19].swp ? cf_r[ag] : sf_r[ag])};
    assign c1   = {1'b0, (oct_r[ag][19].swp ? sf_r[ag] : cf_r[ag])};
    assign sneg = -s1;
    assign cneg = -c1;

    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        // fold
        rf_r[ag]        <= swp ? 13'(QUARTER_TURN - rq) : rq[12:0];
        oct_r[ag][1]    <= '{swp: swp, quad: qd};
        for (int k = 2; k <= 19; k++) oct_r[ag][k] <= oct_r[ag][k-1];
        // angle to Q30 radians
        xa2_r[ag]       <= rf_r[ag] * X_INT;
        xm_r[ag]        <= rf_r[ag] * X_FRAC + 27'(X_BIAS);
        xq_r[ag]        <= xm_r[ag][26:9] * RCP45;
        xa3_r[ag]       <= xa2_r[ag];
        x4_r[ag]        <= xa3_r[ag] + {17'd0, xq_r[ag][36:24]};
        // square
        xx_r[ag]        <= x4_r[ag] * x4_r[ag];
        x5_r[ag]        <= x4_r[ag];
        xp_r[ag][6]     <= '{x: x5_r[ag], x2: x2sum[59:30]};
        for (int k = 7; k <= 16; k++) xp_r[ag][k] <= xp_r[ag][k-1];
        // series results
        sf_r[ag]        <= nm_r[ag][0][5][30:0];
        cf_r[ag]        <= ONE_Q30 - csh[30:0];
        unique case (oct_r[ag][19].quad)
          QUAD_0: begin sn_r[ag] <= s1;   cs_r[ag] <= c1;   end
          QUAD_1: begin sn_r[ag] <= c1;   cs_r[ag] <= sneg; end
          QUAD_2: begin sn_r[ag] <= sneg; cs_r[ag] <= cneg; end
          default: begin sn_r[ag] <= cneg; cs_r[ag] <= s1;  end
        endcase
      end
    end

    // horner series, two stages per step: multiply, then round and divide
    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      for (genvar s = 0; s < 6; s++) begin : g_slot
        logic [30:0] t_in;
        logic [29:0] mop;
        logic [61:0] rsum;
        logic [30:0] nval;
        if (s == 0) begin : g_first
          assign t_in = ONE_Q30;
        end else begin : g_next
          logic [63:0] qsh;
          assign qsh  = nm_r[ag][ln][s-1] >> HORNER_SHF[ln][s-1];
          assign t_in = ONE_Q30 - qsh[30:0];
        end
        assign mop  = (ln == 0 && s == 5) ? xp_r[ag][6+2*s].x : xp_r[ag][6+2*s].x2;
        assign rsum = {1'b0, prod_r[ag][ln][s]} + 62'(HALF_Q30);
        assign nval = rsum[60:30] + {24'd0, HORNER_HALF[ln][s]};
        always_ff @(posedge clk) begin
          if (pipe_adv) begin
            prod_r[ag][ln][s] <= mop * t_in;
            nm_r[ag][ln][s]   <= nval * HORNER_MAG[ln][s];
          end
        end
      end
    end
  end

  // rate products, sums, rounding
  logic [48:0] aneg, prneg;
  logic [48:0] a16sum, prsum;
  logic [31:0] a16mag;
  logic [16:0] prmag17;
  logic [64:0] rneg;
  logic [32:0] a16neg;

  assign aneg    = -a_r;
  assign prneg   = -pr_r;
  assign a16sum  = {1'b0, amag_r} + 49'h2000;
  assign prsum   = {1'b0, prmag_r} + 49'h2000_0000;
  assign a16mag  = a16sum[45:14];
  assign prmag17 = prsum[46:30];
  assign rneg    = -rnum_r;
  assign a16neg  = -a16_r[26];

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      qs_r <= side_r[20].q * sn_r[0];
      rc_r <= side_r[20].r * cs_r[0];
      qc_r <= side_r[20].q * cs_r[0];
      rs_r <= side_r[20].r * sn_r[0];
      st_r[21] <= sn_r[1];
      ct_r[21] <= cs_r[1][30:0];
      for (int k = 22; k <= 24; k++) st_r[k] <= st_r[k-1];
      for (int k = 22; k < ST_OUT; k++) ct_r[k] <= ct_r[k-1];

      a_r  <= 49'(qs_r) + 49'(rc_r);
      pr_r <= 49'(qc_r) - 49'(rs_r);

      amag_r  <= a_r[48] ? aneg[47:0] : a_r[47:0];
      asgn_r  <= a_r[48];
      prmag_r <= pr_r[48] ? prneg[47:0] : pr_r[47:0];
      prsgn_r <= pr_r[48];

      a16_r[24]   <= asgn_r ? -$signed({1'b0, a16mag}) : $signed({1'b0, a16mag});
      prate_r[24] <= prsgn_r ? -$signed(prmag17) : $signed(prmag17);
      for (int k = 25; k <= 26; k++) a16_r[k] <= a16_r[k-1];
      for (int k = 25; k < ST_OUT; k++) prate_r[k] <= prate_r[k-1];

      pc_r <= side_r[24].p * $signed({1'b0, ct_r[24]});
      as_r <= a16_r[24] * st_r[24];

      rnum_r <= 65'($signed({pc_r, 16'h0000})) + as_r;

      rmag_r    <= rnum_r[64] ? rneg[63:0] : rnum_r[63:0];
      ymag_r    <= {(a16_r[26][32] ? a16neg[31:0] : a16_r[26][31:0]), 30'd0};
      sgn_r[27] <= {a16_r[26][32], rnum_r[64]};
      for (int k = 28; k < ST_OUT; k++) sgn_r[k] <= sgn_r[k-1];

      // add half the divisor for round to nearest
      nsum_r[0] <= 72'(rmag_r) + (72'(ct_r[27]) << 15);
      nsum_r[1] <= 72'(ymag_r) + (72'(ct_r[27]) << 15);
    end
  end

  // restoring dividers by cos(pitch) * 2^16, one quotient bit per stage
  for (genvar dl = 0; dl < 2; dl++) begin : g_div
    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        rem_r[dl][0] <= nsum_r[dl];
        ov_r[dl][0]  <= nsum_r[dl] >= (72'(ct_r[28]) << (16 + DIV_STEPS));
        qb_r[dl][0]  <= '0;
      end
    end
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
      logic [71:0] dsh;
      logic        ge;
      assign dsh = 72'(ct_r[28+j]) << (16 + DIV_STEPS - j);
      assign ge  = rem_r[dl][j-1] >= dsh;
      always_ff @(posedge clk) begin
        if (pipe_adv) begin
          rem_r[dl][j] <= ge ? rem_r[dl][j-1] - dsh : rem_r[dl][j-1];
          ov_r[dl][j]  <= ov_r[dl][j-1];
          qb_r[dl][j]  <= {qb_r[dl][j-1][23:0], ge};
        end
      end
    end
  end

  // output register, zero rates when the pitch guard fails
  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      if (side_r[ST_OUT-1].guard) begin
        out_roll_r  <= sat_rate(qb_r[0][DIV_STEPS], ov_r[0][DIV_STEPS], sgn_r[ST_OUT-1][0]);
        out_head_r  <= sat_rate(qb_r[1][DIV_STEPS], ov_r[1][DIV_STEPS], sgn_r[ST_OUT-1][1]);
        out_pitch_r <= 24'(prate_r[ST_OUT-1]);
        out_rv_r    <= 1'b1;
      end else begin
        out_roll_r  <= '0;
        out_head_r  <= '0;
        out_pitch_r <= '0;
        out_rv_r    <= 1'b0;
      end
    end
  end

  assign out_roll_angle_rate  = out_roll_r;
  assign out_pitch_angle_rate = out_pitch_r;
  assign out_heading_rate     = out_head_r;
  assign out_rates_valid      = out_rv_r;

  // checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rates_valid |->
      out_roll_angle_rate == 24'sd0 && out_pitch_angle_rate == 24'sd0 &&
      out_heading_rate == 24'sd0)
    else $error("invalid result carries nonzero rates");

  a_pitch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rates_valid |->
      out_pitch_angle_rate <= 24'sd46342 && out_pitch_angle_rate >= -24'sd46342)
    else $error("pitch rate out of bound");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_OUT-1] && !in_stall |=> out_valid)
    else $error("item lost before output register");

  a_cos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[21] && side_r[21].guard |-> ct_r[21] != 31'd0)
    else $error("zero divisor for guarded pitch");

endmodule
